// ===== src/dibs_pkg.sv =====
package dibs_pkg;

  // CRC-32 as used by zlib: reflected, polynomial 0xEDB88320.
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
  localparam logic [31:0] ALL_ZEROS  = 32'h00000000;

  // Size of one flash slot in bytes; a header size must stay below it.
  localparam logic [31:0] SLOT_BYTES = 32'd65536;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_VERSION      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_SIZE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_STORED_CRC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_VERSION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_SIZE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_STORED_CRC = 3'd5;

  // Item opcodes and slot codes.
  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_DECIDE   = 1'b1;
  localparam logic SLOT_MAIN   = 1'b0;
  localparam logic SLOT_BACKUP = 1'b1;

  // A classified command as it travels from the front through the queue.
  typedef struct packed {
    logic       decide;
    logic       slot;
    logic [7:0] data;
  } cmd_t;

  // One byte of the reflected CRC update, eight shift steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    c = acc ^ {24'h000000, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // A header is plausible if neither word is blank or erased and the size fits the slot.
  function automatic logic header_plausible(input logic [31:0] version,
                                            input logic [31:0] size);
    return (version != ALL_ZEROS) && (version != ALL_ONES) &&
           (size != ALL_ZEROS) && (size != ALL_ONES) && (size < SLOT_BYTES);
  endfunction

endpackage

// ===== src/dual_image_boot_selector.sv =====
// Channel   Direction  Handshake            Payload
// item      in         item_valid/stall     opcode, slot, data_byte
// verdict   out        verdict_valid/stall  main_ok, backup_ok, main_crc, backup_crc,
//                                           copy_backup
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// An item is taken every cycle unless item_stall is high; the byte-wide CRC sets that rate.
// A decide item passes the front register and the queue before its verdict is registered.
// rst is synchronous and active high; it empties the front register, the queue and the
// verdict register, restarts both CRCs and clears the registers. A stalled verdict holds
// back a decide item and everything queued behind it; byte items ahead of it keep draining,
// and input stalls once the queue and the front register fill.
module dual_image_boot_selector #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           opcode,
  input  logic                           slot,
  input  logic [7:0]                     data_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dibs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           verdict_valid,
  input  logic                           verdict_stall,
  output logic                           main_ok,
  output logic                           backup_ok,
  output logic [31:0]                    main_crc,
  output logic [31:0]                    backup_crc,
  output logic                           copy_backup
);

  logic           push_valid;
  dibs_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_valid;
  dibs_pkg::cmd_t q_cmd;
  logic           q_pop;

  // Front end: accept and classify.
  dibs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .slot       (slot),
    .data_byte  (data_byte),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  // Command queue between the two halves.
  dibs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // Back end: CRC engines, registers and verdict.
  dibs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .main_ok       (main_ok),
    .backup_ok     (backup_ok),
    .main_crc      (main_crc),
    .backup_crc    (backup_crc),
    .copy_backup   (copy_backup)
  );

endmodule

// ===== src/dibs_front.sv =====
module dibs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             opcode,
  input  logic             slot,
  input  logic [7:0]       data_byte,
  output logic             push_valid,
  output dibs_pkg::cmd_t   push_cmd,
  input  logic             q_full
);

  logic           held;
  dibs_pkg::cmd_t held_cmd;

  // The holding register drains into the queue whenever the queue has room.
  assign item_stall = held && q_full;
  assign push_valid = held;
  assign push_cmd   = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  // Classify the beat: a decide item carries no byte or slot.
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_cmd.decide <= (opcode == dibs_pkg::OP_DECIDE);
      held_cmd.slot   <= (opcode == dibs_pkg::OP_DECIDE) ? dibs_pkg::SLOT_MAIN : slot;
      held_cmd.data   <= (opcode == dibs_pkg::OP_DECIDE) ? 8'h00 : data_byte;
    end
  end

endmodule

// ===== src/dibs_queue.sv =====
module dibs_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  dibs_pkg::cmd_t   push_cmd,
  output logic             full,
  output logic             pop_valid,
  output dibs_pkg::cmd_t   pop_cmd,
  input  logic             pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dibs_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/dibs_back.sv =====
module dibs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dibs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           q_valid,
  input  dibs_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  output logic                           verdict_valid,
  input  logic                           verdict_stall,
  output logic                           main_ok,
  output logic                           backup_ok,
  output logic [31:0]                    main_crc,
  output logic [31:0]                    backup_crc,
  output logic                           copy_backup
);

  logic [31:0] main_version;
  logic [31:0] main_size;
  logic [31:0] main_stored_crc;
  logic [31:0] backup_version;
  logic [31:0] backup_size;
  logic [31:0] backup_stored_crc;
  logic [31:0] main_crc_acc;
  logic [31:0] backup_crc_acc;

  logic        out_free;
  logic        do_byte;
  logic        do_decide;
  logic        m_plaus;
  logic        b_plaus;
  logic [31:0] m_crc;
  logic [31:0] b_crc;
  logic        m_ok;
  logic        b_ok;
  logic        copy;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_version      <= '0;
      main_size         <= '0;
      main_stored_crc   <= '0;
      backup_version    <= '0;
      backup_size       <= '0;
      backup_stored_crc <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dibs_pkg::REG_MAIN_VERSION:      main_version      <= cfg_data;
        dibs_pkg::REG_MAIN_SIZE:         main_size         <= cfg_data;
        dibs_pkg::REG_MAIN_STORED_CRC:   main_stored_crc   <= cfg_data;
        dibs_pkg::REG_BACKUP_VERSION:    backup_version    <= cfg_data;
        dibs_pkg::REG_BACKUP_SIZE:       backup_size       <= cfg_data;
        dibs_pkg::REG_BACKUP_STORED_CRC: backup_stored_crc <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte commands never wait; a decide waits until the verdict register is free.
  assign out_free  = !verdict_valid || !verdict_stall;
  assign q_pop     = q_valid && (!q_cmd.decide || out_free);
  assign do_byte   = q_pop && !q_cmd.decide;
  assign do_decide = q_pop && q_cmd.decide;

  // Verdict from headers, finished CRCs and versions.
  always_comb begin
    m_plaus = dibs_pkg::header_plausible(main_version, main_size);
    b_plaus = dibs_pkg::header_plausible(backup_version, backup_size);
    m_crc   = m_plaus ? ~main_crc_acc : dibs_pkg::ALL_ZEROS;
    b_crc   = b_plaus ? ~backup_crc_acc : dibs_pkg::ALL_ZEROS;
    m_ok    = m_plaus && (m_crc == main_stored_crc);
    b_ok    = b_plaus && (b_crc == backup_stored_crc);
    if (m_ok && b_ok) begin
      copy = main_version < backup_version;
    end else begin
      copy = b_ok && !m_ok;
    end
  end

  // Running CRCs; a decide restarts both.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_crc_acc   <= dibs_pkg::ALL_ONES;
      backup_crc_acc <= dibs_pkg::ALL_ONES;
    end else if (do_decide) begin
      main_crc_acc   <= dibs_pkg::ALL_ONES;
      backup_crc_acc <= dibs_pkg::ALL_ONES;
    end else if (do_byte) begin
      if (q_cmd.slot == dibs_pkg::SLOT_BACKUP) begin
        backup_crc_acc <= dibs_pkg::crc_byte(backup_crc_acc, q_cmd.data);
      end else begin
        main_crc_acc <= dibs_pkg::crc_byte(main_crc_acc, q_cmd.data);
      end
    end
  end

  // Verdict output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (do_decide) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_decide) begin
      main_ok     <= m_ok;
      backup_ok   <= b_ok;
      main_crc    <= m_crc;
      backup_crc  <= b_crc;
      copy_backup <= copy;
    end
  end

endmodule

// ===== src/dibs_checker.sv =====
module dibs_checker (
  input logic        clk,
  input logic        rst,
  input logic        verdict_valid,
  input logic        verdict_stall,
  input logic        main_ok,
  input logic        backup_ok,
  input logic [31:0] main_crc,
  input logic [31:0] backup_crc,
  input logic        copy_backup
);

  // A stalled verdict beat holds its value.
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid &&
      $stable(main_ok) && $stable(backup_ok) && $stable(main_crc) &&
      $stable(backup_crc) && $stable(copy_backup))
    else $error("verdict changed while stalled");

  // No verdict is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !verdict_valid)
    else $error("verdict valid right after reset");

  // Copying is only asked for when the backup checks out.
  a_copy_needs_backup: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && copy_backup |-> backup_ok)
    else $error("copy requested with a bad backup");

  // A good main with a bad backup never triggers a copy.
  a_keep_main: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && main_ok && !backup_ok |-> !copy_backup)
    else $error("copy requested over the only good image");

endmodule

bind dual_image_boot_selector dibs_checker u_dibs_checker (.*);
